// ===== rtl/steq_pkg.sv =====
`timescale 1ns / 1ps
// steq_pkg: shared widths, defaults and the command record for the
// sorted table equal-range search block; no dependencies
package steq_pkg;

    // field widths of the input and result transfers
    localparam int KEY_W      = 48;
    localparam int TAG_W      = 32;
    localparam int ENTRY_IX_W = 10;
    localparam int COUNT_W    = 11;

    // defaults for the top level parameters
    localparam int DEF_TABLE_DEPTH = 1024;
    localparam int DEF_MAX_MATCHES = 16;

    // command queue between front and engine
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    // classified item handed from the front to the engine
    typedef struct packed {
        op_t                   op;
        logic [ENTRY_IX_W-1:0] index;
        logic [KEY_W-1:0]      start;
        logic [KEY_W-1:0]      value;   // stored end value or searched key
        logic [TAG_W-1:0]      tag;
    } cmd_t;

endpackage

// ===== rtl/steq_if.sv =====
`timescale 1ns / 1ps
// steq_req_if and steq_rsp_if: valid/ready channels for input items and
// result items; depends on steq_pkg for field widths

interface steq_req_if;
    import steq_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  mode;
    logic [ENTRY_IX_W-1:0] entry_index;
    logic [KEY_W-1:0]      entry_start;
    logic [KEY_W-1:0]      entry_end;
    logic [KEY_W-1:0]      query_key;
    logic [TAG_W-1:0]      query_tag;

    modport source (
        output valid, mode, entry_index, entry_start, entry_end, query_key, query_tag,
        input  ready
    );
    modport sink (
        input  valid, mode, entry_index, entry_start, entry_end, query_key, query_tag,
        output ready
    );
endinterface

interface steq_rsp_if;
    import steq_pkg::*;

    logic             valid;
    logic             ready;
    logic             found;
    logic [KEY_W-1:0] match_start;
    logic [KEY_W-1:0] match_end;
    logic [TAG_W-1:0] match_tag;
    logic             last;
    logic             truncated;

    modport source (
        output valid, found, match_start, match_end, match_tag, last, truncated,
        input  ready
    );
    modport sink (
        input  valid, found, match_start, match_end, match_tag, last, truncated,
        output ready
    );
endinterface

// ===== rtl/steq_front.sv =====
`timescale 1ns / 1ps
// steq_front: accepts input transfers, classifies them into load or query
// commands and queues them for the engine; depends on steq_pkg, steq_if
module steq_front (
    input  logic            clk,
    input  logic            rst_n,
    steq_req_if.sink        req,
    output logic            cmd_valid,
    input  logic            cmd_ready,
    output steq_pkg::cmd_t  cmd
);
    import steq_pkg::*;

    localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t              q_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [FILL_W-1:0] fill_reg;
    cmd_t              cls_cmd;
    logic              push;
    logic              pop;

    // classify the incoming item
    always_comb
    begin
        cls_cmd.op    = req.mode ? OP_QUERY : OP_LOAD;
        cls_cmd.index = req.entry_index;
        cls_cmd.start = req.entry_start;
        cls_cmd.value = req.mode ? req.query_key : req.entry_end;
        cls_cmd.tag   = req.query_tag;
    end

    // queue handshakes
    assign req.ready = (fill_reg != FILL_W'(QUEUE_DEPTH));
    assign push      = req.valid && req.ready;
    assign cmd_valid = (fill_reg != '0);
    assign pop       = cmd_valid && cmd_ready;
    assign cmd       = q_mem[rd_ptr_reg];

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= cls_cmd;
        end
    end

    // queue pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/steq_engine.sv =====
`timescale 1ns / 1ps
// steq_engine: table memory, binary search, neighbour scan and result
// emission with an output register; depends on steq_pkg, steq_if
module steq_engine #(
    parameter int TABLE_DEPTH = steq_pkg::DEF_TABLE_DEPTH,
    parameter int MAX_MATCHES = steq_pkg::DEF_MAX_MATCHES
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    output logic                          cmd_ready,
    input  steq_pkg::cmd_t                cmd,
    input  logic                          cfg_we,
    input  logic [steq_pkg::COUNT_W-1:0]  cfg_wdata,
    steq_rsp_if.source                    rsp
);
    import steq_pkg::*;

    localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int N_W    = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
    localparam int HIT_W  = (MAX_MATCHES > 1) ? $clog2(MAX_MATCHES) : 1;
    localparam int MCNT_W = $clog2(MAX_MATCHES + 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SINGLE,
        S_PADDR,
        S_PCMP,
        S_DADDR,
        S_DCMP,
        S_UADDR,
        S_UCMP,
        S_EADDR,
        S_EDATA
    } state_t;

    state_t              state_reg;
    logic [COUNT_W-1:0]  table_count_reg;
    logic [N_W-1:0]      n_reg;
    logic [N_W-1:0]      lo_reg;
    logic [N_W-1:0]      hi_reg;
    logic [N_W-1:0]      mid_reg;
    logic [N_W-1:0]      j_reg;
    logic [MCNT_W-1:0]   cnt_reg;
    logic [HIT_W-1:0]    e_ptr_reg;
    logic                trunc_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [TAG_W-1:0]    tag_reg;

    logic [2*KEY_W-1:0]  mem [TABLE_DEPTH];
    logic [2*KEY_W-1:0]  rd_data_reg;
    logic [IDX_W-1:0]    hit_buf [MAX_MATCHES];

    logic                o_valid_reg;
    logic                o_found_reg;
    logic [KEY_W-1:0]    o_start_reg;
    logic [KEY_W-1:0]    o_end_reg;
    logic [TAG_W-1:0]    o_tag_reg;
    logic                o_last_reg;
    logic                o_trunc_reg;

    logic                take;
    logic [N_W-1:0]      count_ext;
    logic [N_W-1:0]      n_eff;
    logic                mem_we;
    logic [IDX_W-1:0]    wr_addr;
    logic [N_W-1:0]      mid;
    logic                rd_en;
    logic [IDX_W-1:0]    rd_addr;
    logic [KEY_W-1:0]    rd_end;
    logic                eq;
    logic                room;
    logic [N_W-1:0]      up_first;
    logic                up_none;
    logic                j_up_end;
    logic                e_last;
    logic                out_load;
    logic                res_we;
    logic                hit_we;
    logic [HIT_W-1:0]    hit_addr;
    logic [IDX_W-1:0]    hit_wdata;

    // command pop and effective table size
    assign cmd_ready = (state_reg == S_IDLE);
    assign take      = cmd_valid && cmd_ready;
    assign count_ext = N_W'(table_count_reg);
    assign n_eff     = (count_ext > N_W'(TABLE_DEPTH)) ? N_W'(TABLE_DEPTH) : count_ext;

    // load write path
    assign mem_we  = take && (cmd.op == OP_LOAD) && (N_W'(cmd.index) < N_W'(TABLE_DEPTH));
    assign wr_addr = IDX_W'(N_W'(cmd.index));

    // probe position inside the open window
    assign mid = (hi_reg > lo_reg) ? lo_reg + ((hi_reg - lo_reg - 1'b1) >> 1) : lo_reg;

    // read address select
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = '0;
        unique case (state_reg)
            S_PADDR:
            begin
                rd_en   = 1'b1;
                rd_addr = mid[IDX_W-1:0];
            end
            S_DADDR, S_UADDR:
            begin
                rd_en   = 1'b1;
                rd_addr = j_reg[IDX_W-1:0];
            end
            S_EADDR:
            begin
                rd_en   = 1'b1;
                rd_addr = hit_buf[e_ptr_reg];
            end
            default:
            begin
                rd_en   = 1'b0;
                rd_addr = '0;
            end
        endcase
    end

    // table memory, end value in the low half
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= {cmd.start, cmd.value};
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // compare and scan conditions
    assign rd_end   = rd_data_reg[KEY_W-1:0];
    assign eq       = (rd_end == key_reg);
    assign room     = (cnt_reg < MCNT_W'(MAX_MATCHES));
    assign up_first = mid_reg + 1'b1;
    assign up_none  = (up_first >= n_reg);
    assign j_up_end = ((j_reg + 1'b1) >= n_reg);
    assign e_last   = ((MCNT_W'(e_ptr_reg) + MCNT_W'(1)) == cnt_reg);

    // output register load
    assign out_load = !o_valid_reg || rsp.ready;
    assign res_we   = out_load && ((state_reg == S_SINGLE) || (state_reg == S_EDATA));

    // hit index buffer write
    always_comb
    begin
        hit_we    = 1'b0;
        hit_addr  = cnt_reg[HIT_W-1:0];
        hit_wdata = j_reg[IDX_W-1:0];
        unique case (state_reg)
            S_PCMP:
            begin
                hit_we    = eq;
                hit_addr  = '0;
                hit_wdata = mid_reg[IDX_W-1:0];
            end
            S_DCMP, S_UCMP:
            begin
                hit_we = eq && room;
            end
            default:
            begin
                hit_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (hit_we)
        begin
            hit_buf[hit_addr] <= hit_wdata;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (res_we)
        begin
            if (state_reg == S_EDATA)
            begin
                o_found_reg <= 1'b1;
                o_start_reg <= rd_data_reg[2*KEY_W-1:KEY_W];
                o_end_reg   <= rd_end;
                o_last_reg  <= e_last;
                o_trunc_reg <= trunc_reg;
            end
            else
            begin
                o_found_reg <= 1'b0;
                o_start_reg <= '0;
                o_end_reg   <= '0;
                o_last_reg  <= 1'b1;
                o_trunc_reg <= 1'b0;
            end
            o_tag_reg <= tag_reg;
        end
    end

    assign rsp.valid       = o_valid_reg;
    assign rsp.found       = o_found_reg;
    assign rsp.match_start = o_start_reg;
    assign rsp.match_end   = o_end_reg;
    assign rsp.match_tag   = o_tag_reg;
    assign rsp.last        = o_last_reg;
    assign rsp.truncated   = o_trunc_reg;

    // search sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            table_count_reg <= '0;
            n_reg           <= '0;
            lo_reg          <= '0;
            hi_reg          <= '0;
            mid_reg         <= '0;
            j_reg           <= '0;
            cnt_reg         <= '0;
            e_ptr_reg       <= '0;
            trunc_reg       <= 1'b0;
            key_reg         <= '0;
            tag_reg         <= '0;
            o_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                table_count_reg <= cfg_wdata;
            end

            if (res_we)
            begin
                o_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                o_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (take)
                    begin
                        cnt_reg   <= '0;
                        trunc_reg <= 1'b0;
                        key_reg   <= cmd.value;
                        n_reg     <= n_eff;
                        lo_reg    <= '0;
                        hi_reg    <= n_eff;
                        if (cmd.op == OP_LOAD)
                        begin
                            tag_reg   <= '0;
                            state_reg <= S_SINGLE;
                        end
                        else
                        begin
                            tag_reg   <= cmd.tag;
                            state_reg <= (n_eff == '0) ? S_SINGLE : S_PADDR;
                        end
                    end
                end

                S_SINGLE:
                begin
                    if (out_load)
                    begin
                        state_reg <= S_IDLE;
                    end
                end

                S_PADDR:
                begin
                    mid_reg   <= mid;
                    state_reg <= S_PCMP;
                end

                S_PCMP:
                begin
                    if (eq)
                    begin
                        cnt_reg <= MCNT_W'(1);
                        if (mid_reg == '0)
                        begin
                            j_reg     <= up_first;
                            state_reg <= up_none ? S_EADDR : S_UADDR;
                            e_ptr_reg <= '0;
                        end
                        else
                        begin
                            j_reg     <= mid_reg - 1'b1;
                            state_reg <= S_DADDR;
                        end
                    end
                    else if (hi_reg <= lo_reg + 1'b1)
                    begin
                        state_reg <= S_SINGLE;
                    end
                    else
                    begin
                        if (rd_end < key_reg)
                        begin
                            lo_reg <= mid_reg + 1'b1;
                        end
                        else
                        begin
                            hi_reg <= mid_reg;
                        end
                        state_reg <= S_PADDR;
                    end
                end

                S_DADDR:
                begin
                    state_reg <= S_DCMP;
                end

                S_DCMP:
                begin
                    e_ptr_reg <= '0;
                    if (eq && room)
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                        if (j_reg == '0)
                        begin
                            j_reg     <= up_first;
                            state_reg <= up_none ? S_EADDR : S_UADDR;
                        end
                        else
                        begin
                            j_reg     <= j_reg - 1'b1;
                            state_reg <= S_DADDR;
                        end
                    end
                    else if (eq)
                    begin
                        trunc_reg <= 1'b1;
                        state_reg <= S_EADDR;
                    end
                    else
                    begin
                        j_reg     <= up_first;
                        state_reg <= up_none ? S_EADDR : S_UADDR;
                    end
                end

                S_UADDR:
                begin
                    state_reg <= S_UCMP;
                end

                S_UCMP:
                begin
                    e_ptr_reg <= '0;
                    if (eq && room)
                    begin
                        cnt_reg   <= cnt_reg + 1'b1;
                        j_reg     <= j_reg + 1'b1;
                        state_reg <= j_up_end ? S_EADDR : S_UADDR;
                    end
                    else
                    begin
                        trunc_reg <= eq;
                        state_reg <= S_EADDR;
                    end
                end

                S_EADDR:
                begin
                    state_reg <= S_EDATA;
                end

                S_EDATA:
                begin
                    if (out_load)
                    begin
                        if (e_last)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            e_ptr_reg <= e_ptr_reg + 1'b1;
                            state_reg <= S_EADDR;
                        end
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef ASSERT_OFF
    // hit count stays within the kept-match limit
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= MCNT_W'(MAX_MATCHES))
        else $error("hit count above limit");

    // emission only runs with at least one recorded hit
    a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EADDR || state_reg == S_EDATA) |-> (cnt_reg != '0))
        else $error("emission without hits");

    // probe window stays ordered and inside the table, it may close to a single point
    a_probe_window: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PADDR) |-> (lo_reg <= hi_reg) && (hi_reg <= n_reg))
        else $error("probe window out of range");

    // a pending result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        res_we |-> (!o_valid_reg || rsp.ready))
        else $error("result register overwritten");

    // truncation is only flagged on match results
    a_trunc_found: assert property (@(posedge clk) disable iff (!rst_n)
        (o_valid_reg && o_trunc_reg) |-> o_found_reg)
        else $error("truncated flag without match");
`endif

endmodule

// ===== rtl/sorted_table_equal_range_search.sv =====
`timescale 1ns / 1ps
// Sequence: a load writes the table and acknowledges with a not-found result; a query
// runs binary-search probes (up to log2(TABLE_DEPTH)+1), each an address and a compare
// state, then neighbour reads, then emits the results, all on the one registered read port.
// Throughput: one item at a time in the engine; a 2-entry queue takes input until full.
// Reset: control clears and table_count is 0; table contents are undefined until loaded,
// with no clearing pass, so the block is ready as soon as reset is released.
module sorted_table_equal_range_search #(
    parameter int TABLE_DEPTH = steq_pkg::DEF_TABLE_DEPTH,
    parameter int MAX_MATCHES = steq_pkg::DEF_MAX_MATCHES
) (
    input  logic                          clk,
    input  logic                          rst_n,
    steq_req_if.sink                      req,
    steq_rsp_if.source                    rsp,
    input  logic                          cfg_we,
    input  logic [steq_pkg::COUNT_W-1:0]  cfg_wdata
);
    import steq_pkg::*;

    logic cmd_valid;
    logic cmd_ready;
    cmd_t cmd;

    // accept and classify
    steq_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    // search and emit
    steq_engine #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .MAX_MATCHES (MAX_MATCHES)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .rsp       (rsp)
    );

endmodule
